[sv/bpse_pkg.sv]
// Shared types and constants for the byte pair substitution encoder.
package bpse_pkg;

  localparam int ByteW      = 8;
  localparam int PairIdxW   = 2 * ByteW;
  localparam int TableDepth = 1 << PairIdxW;
  localparam int MaxOut     = 4;
  localparam int OutCntW    = $clog2(MaxOut + 1);
  localparam int OutIdxW    = $clog2(MaxOut);

  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegCommon = 1'b0;
  localparam logic [CfgIdxW-1:0] RegEscape = 1'b1;

  localparam logic CmdData  = 1'b0;
  localparam logic CmdTable = 1'b1;

  typedef struct packed {
    logic                cmd;
    logic [ByteW-1:0]    in_byte;
    logic                is_last;
    logic [PairIdxW-1:0] table_index;
    logic [ByteW-1:0]    table_value;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             out_item_last;
    logic             out_stream_end;
  } out_item_t;

  // data byte held between the table lookup and the emit stage
  typedef struct packed {
    logic [ByteW-1:0] cur_byte;
    logic [ByteW-1:0] prev_byte;
    logic             is_last;
  } stage_t;

endpackage

[sv/bpse_table.sv]
// Pair table: one write port, two registered read ports.
module bpse_table (
  input  logic                          clk,
  input  logic                          we,
  input  logic [bpse_pkg::PairIdxW-1:0] waddr,
  input  logic [bpse_pkg::ByteW-1:0]    wdata,
  input  logic                          re,
  input  logic [bpse_pkg::PairIdxW-1:0] raddr_a,
  input  logic [bpse_pkg::PairIdxW-1:0] raddr_b,
  output logic [bpse_pkg::ByteW-1:0]    rdata_a,
  output logic [bpse_pkg::ByteW-1:0]    rdata_b
);
  import bpse_pkg::*;

  logic [ByteW-1:0] mem [0:TableDepth-1];
  logic [ByteW-1:0] rdata_a_r;
  logic [ByteW-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

[sv/bpse_emit.sv]
// Pair decision, pending byte tracking and result byte sequencing.
module bpse_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s1_valid,
  input  bpse_pkg::stage_t           s1_item,
  input  logic [bpse_pkg::ByteW-1:0] pair_code,
  input  logic [bpse_pkg::ByteW-1:0] flush_code,
  input  logic [bpse_pkg::ByteW-1:0] plain_code,
  input  logic [bpse_pkg::ByteW-1:0] esc_code,
  output logic                       s1_adv,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bpse_pkg::out_item_t        out_data
);
  import bpse_pkg::*;

  logic                           pend_valid_r, pend_valid_nxt;
  logic                           ex_valid_r, ex_valid_nxt;
  logic [MaxOut-1:0][ByteW-1:0]   ex_bytes_r, ex_bytes_nxt;
  logic [OutIdxW-1:0]             ex_top_r, ex_top_nxt;
  logic [OutIdxW-1:0]             ex_idx_r, ex_idx_nxt;
  logic                           ex_end_r, ex_end_nxt;

  logic [MaxOut-1:0][ByteW-1:0]   lst;
  logic [OutCntW-1:0]             lst_n;
  logic                           keep;
  logic                           beat;
  logic                           ex_at_top;
  logic                           ex_done;

  // build the result list for the byte in stage 1
  always_comb begin
    lst   = '0;
    lst_n = '0;
    keep  = 1'b1;
    if (pend_valid_r) begin
      if (pair_code == plain_code) begin
        lst[0] = s1_item.prev_byte;
        lst_n  = OutCntW'(1);
      end else if (pair_code == esc_code) begin
        lst[0] = esc_code;
        lst[1] = s1_item.prev_byte;
        lst_n  = OutCntW'(2);
      end else begin
        lst[0] = pair_code;
        lst_n  = OutCntW'(1);
        keep   = 1'b0;
      end
    end
    // flush at end of stream
    if (s1_item.is_last && keep) begin
      if (flush_code == esc_code && esc_code != plain_code) begin
        lst[lst_n[OutIdxW-1:0]] = esc_code;
        lst_n = lst_n + OutCntW'(1);
      end
      lst[lst_n[OutIdxW-1:0]] = s1_item.cur_byte;
      lst_n = lst_n + OutCntW'(1);
    end
  end

  assign beat      = ex_valid_r && !out_stall;
  assign ex_at_top = (ex_idx_r == ex_top_r);
  assign ex_done   = beat && ex_at_top;
  assign s1_adv    = s1_valid && (!ex_valid_r || ex_done);

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    ex_valid_nxt   = ex_valid_r;
    ex_bytes_nxt   = ex_bytes_r;
    ex_top_nxt     = ex_top_r;
    ex_idx_nxt     = ex_idx_r;
    ex_end_nxt     = ex_end_r;
    if (beat) begin
      if (ex_at_top) begin
        ex_valid_nxt = 1'b0;
      end else begin
        ex_idx_nxt = ex_idx_r + OutIdxW'(1);
      end
    end
    if (s1_adv) begin
      pend_valid_nxt = keep && !s1_item.is_last;
      if (lst_n != '0) begin
        ex_valid_nxt = 1'b1;
        ex_bytes_nxt = lst;
        ex_top_nxt   = OutIdxW'(lst_n - OutCntW'(1));
        ex_idx_nxt   = '0;
        ex_end_nxt   = s1_item.is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      ex_valid_r   <= 1'b0;
      ex_idx_r     <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      ex_valid_r   <= ex_valid_nxt;
      ex_idx_r     <= ex_idx_nxt;
    end
    ex_bytes_r <= ex_bytes_nxt;
    ex_top_r   <= ex_top_nxt;
    ex_end_r   <= ex_end_nxt;
  end

  assign out_valid               = ex_valid_r;
  assign out_data.out_byte       = ex_bytes_r[ex_idx_r];
  assign out_data.out_item_last  = ex_at_top;
  assign out_data.out_stream_end = ex_at_top && ex_end_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ex_valid_r |-> ex_idx_r <= ex_top_r)
    else $error("emit index past end of result list");

  a_end_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && out_data.out_stream_end) |-> !pend_valid_r)
    else $error("pending byte still held at end of stream");

  a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item.is_last) |=> !pend_valid_r)
    else $error("last byte left a pending byte");

  a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && !ex_at_top) |=> ex_valid_r && ex_idx_r == $past(ex_idx_r) + OutIdxW'(1))
    else $error("result sequence skipped or lost a beat");

endmodule

[sv/byte_pair_substitution_encoder_top.sv]
// Byte pair substitution encoder: a data beat and its pair table reads are registered in stage 1,
// then its results in the output sequencer. One beat accepted per cycle while each data byte yields
// at most one result and out_stall is low; a byte with more results holds the output sequencer until
// all are sent. Table writes give no result. The lookup uses both read ports of the pair table in
// the accepting cycle. Synchronous active-low reset clears the valid flags, the codes and the pending
// byte; the table is not cleared and must be loaded before data flows.
module byte_pair_substitution_encoder_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bpse_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bpse_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [bpse_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [bpse_pkg::ByteW-1:0]          cfg_wdata
);
  import bpse_pkg::*;

  logic [ByteW-1:0] common_r;
  logic [ByteW-1:0] escape_r;
  logic [ByteW-1:0] last_byte_r;
  logic             s1_valid_r, s1_valid_nxt;
  stage_t           s1_item_r;
  logic             in_acc;
  logic             data_acc;
  logic             s1_adv;
  logic [ByteW-1:0] pair_code;
  logic [ByteW-1:0] flush_code;

  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign data_acc = in_acc && (in_data.cmd == CmdData);

  assign s1_valid_nxt = data_acc || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      common_r   <= '0;
      escape_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          RegCommon: common_r <= cfg_wdata;
          RegEscape: escape_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    if (data_acc) begin
      last_byte_r         <= in_data.in_byte;
      s1_item_r.cur_byte  <= in_data.in_byte;
      s1_item_r.prev_byte <= last_byte_r;
      s1_item_r.is_last   <= in_data.is_last;
    end
  end

  // pair address uses the previous data byte; only meaningful when a byte is pending
  bpse_table u_table (
    .clk     (clk),
    .we      (in_acc && (in_data.cmd == CmdTable)),
    .waddr   (in_data.table_index),
    .wdata   (in_data.table_value),
    .re      (data_acc),
    .raddr_a ({last_byte_r, in_data.in_byte}),
    .raddr_b ({in_data.in_byte, ByteW'(0)}),
    .rdata_a (pair_code),
    .rdata_b (flush_code)
  );

  bpse_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .s1_valid    (s1_valid_r),
    .s1_item     (s1_item_r),
    .pair_code   (pair_code),
    .flush_code  (flush_code),
    .plain_code  (common_r),
    .esc_code    (escape_r),
    .s1_adv      (s1_adv),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the byte pair substitution encoder top level.
module tb;
  import bpse_pkg::*;

  localparam int Latency    = 8;
  localparam int Phases     = 7;
  localparam int PhaseBeats = 40;
  localparam int AlphaN     = 6;
  localparam logic [ByteW-1:0] PhaseCommon [Phases] =
    '{8'h00, 8'hFF, 8'h01, 8'hFF, 8'h02, 8'h00, 8'h00};
  localparam logic [ByteW-1:0] PhaseEscape [Phases] =
    '{8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h02, 8'h00};

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [ByteW-1:0]     cfg_wdata = '0;

  byte_pair_substitution_encoder_top u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [ByteW-1:0] pair_code [TableDepth];
  logic [ByteW-1:0] held_byte   = '0;
  logic             held        = 1'b0;
  logic [ByteW-1:0] common_code = '0;
  logic [ByteW-1:0] escape_code = '0;
  out_item_t        encoded_q [$];

  int n_beats, n_writes, n_results, n_streams, n_settings, n_err;
  bit in_calm, out_calm;
  int stall_left;
  logic [ByteW-1:0] alphabet [AlphaN];

  // Works out the encoded beats caused by one accepted input beat.
  task automatic encode_beat(input in_item_t it);
    logic [ByteW-1:0] emit [$];
    logic [ByteW-1:0] code;
    out_item_t        beat;
    if (it.cmd == CmdTable) begin
      pair_code[it.table_index] = it.table_value;
      n_writes++;
      return;
    end
    if (held) begin
      code = pair_code[{held_byte, it.in_byte}];
      if (code == common_code) begin
        emit = {emit, held_byte};
        held_byte = it.in_byte;
      end else if (code == escape_code) begin
        emit = {emit, escape_code};
        emit = {emit, held_byte};
        held_byte = it.in_byte;
      end else begin
        emit = {emit, code};
        held = 1'b0;
      end
    end else begin
      held_byte = it.in_byte;
      held      = 1'b1;
    end
    if (it.is_last) begin
      if (held) begin
        code = pair_code[{held_byte, 8'h00}];
        if (code == escape_code && escape_code != common_code)
          emit = {emit, escape_code};
        emit = {emit, held_byte};
      end
      held      = 1'b0;
      held_byte = '0;
    end
    foreach (emit[i]) begin
      beat.out_byte       = emit[i];
      beat.out_item_last  = (i == emit.size() - 1);
      beat.out_stream_end = it.is_last && (i == emit.size() - 1);
      encoded_q = {encoded_q, beat};
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          RegCommon: common_code = cfg_wdata;
          RegEscape: escape_code = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        n_beats++;
        if (in_data.cmd == CmdData && in_data.is_last) n_streams++;
        encode_beat(in_data);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (encoded_q.size() == 0) begin
          n_err++;
          $display("%0t: beat %h arrived with none expected", $time, out_data);
        end else begin
          want = encoded_q.pop_front();
          if (out_data.out_byte !== want.out_byte) begin
            n_err++;
            $display("%0t: out_byte expected %h got %h", $time, want.out_byte,
                     out_data.out_byte);
          end
          if (out_data.out_item_last !== want.out_item_last) begin
            n_err++;
            $display("%0t: out_item_last expected %b got %b", $time, want.out_item_last,
                     out_data.out_item_last);
          end
          if (out_data.out_stream_end !== want.out_stream_end) begin
            n_err++;
            $display("%0t: out_stream_end expected %b got %b", $time, want.out_stream_end,
                     out_data.out_stream_end);
          end
        end
      end
    end
  end

  // receiver back-pressure: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    if (stall_left == 0 && !out_calm && $urandom_range(0, 99) < 20)
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  function automatic int in_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Valid stays high after acceptance so that the next call can follow back to back.
  task automatic send_beat(input in_item_t it);
    int gap;
    gap = in_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every encoded beat is in, plus the pipeline depth.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (encoded_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_codes(input logic [ByteW-1:0] common, input logic [ByteW-1:0] escape);
    write_reg(RegCommon, common);
    write_reg(RegEscape, escape);
    n_settings++;
  endtask

  task automatic put_entry(input logic [PairIdxW-1:0] idx, input logic [ByteW-1:0] val);
    in_item_t it;
    it.cmd         = CmdTable;
    it.in_byte     = ByteW'($urandom_range(0, 255));
    it.is_last     = 1'($urandom_range(0, 1));
    it.table_index = idx;
    it.table_value = val;
    send_beat(it);
  endtask

  task automatic put_byte(input logic [ByteW-1:0] b, input logic last);
    in_item_t it;
    it.cmd         = CmdData;
    it.in_byte     = b;
    it.is_last     = last;
    it.table_index = PairIdxW'($urandom_range(0, 65535));
    it.table_value = ByteW'($urandom_range(0, 255));
    send_beat(it);
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    return alphabet[$urandom_range(0, AlphaN - 1)];
  endfunction

  // skewed towards the values the phases use as common and escape codes
  function automatic logic [ByteW-1:0] load_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'h00;
    if (r < 55) return 8'hFF;
    if (r < 65) return 8'h01;
    if (r < 72) return 8'h02;
    return ByteW'($urandom_range(0, 255));
  endfunction

  function automatic in_item_t random_beat();
    in_item_t it;
    int       r;
    it.cmd         = CmdData;
    it.in_byte     = pick_byte();
    it.is_last     = ($urandom_range(0, 7) == 0);
    it.table_index = {pick_byte(), pick_byte()};
    r = $urandom_range(0, 99);
    if (r < 30)      it.table_value = common_code;
    else if (r < 55) it.table_value = escape_code;
    else             it.table_value = ByteW'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 15) it.cmd = CmdTable;
    return it;
  endfunction

  // Random data bytes come only from the alphabet, and 00 is in it, so every pair and
  // every flush entry that traffic can read gets an entry here.
  task automatic load_pair_table();
    alphabet[0] = 8'h00;
    alphabet[1] = 8'hFF;
    alphabet[2] = 8'h01;
    alphabet[3] = 8'h02;
    for (int k = 4; k < AlphaN; k++) alphabet[k] = ByteW'($urandom_range(3, 254));
    in_calm  = 1'b1;
    out_calm = 1'b1;
    for (int a = 0; a < AlphaN; a++)
      for (int b = 0; b < AlphaN; b++) put_entry({alphabet[a], alphabet[b]}, load_value());
    in_calm  = 1'b0;
    out_calm = 1'b0;
  endtask

  task automatic test_single_byte();
    // reset codes: escaping off, so a matching (byte, 0) entry adds nothing
    put_entry(16'h4100, 8'h00);
    put_byte(8'h41, 1'b1);
    settle();
    set_codes(8'h00, 8'hFF);
    put_entry(16'h4200, 8'hFF);
    put_byte(8'h42, 1'b1);
  endtask

  task automatic test_common_pair();
    put_entry(16'h1020, 8'h00);
    put_entry(16'h2000, 8'h00);
    put_byte(8'h10, 1'b0);
    put_byte(8'h20, 1'b1);
  endtask

  // escaped pair and escaped flush: four beats from one byte
  task automatic test_escape_pair();
    put_entry(16'h3040, 8'hFF);
    put_entry(16'h4000, 8'hFF);
    put_byte(8'h30, 1'b0);
    put_byte(8'h40, 1'b1);
  endtask

  task automatic test_replaced_pair();
    put_entry(16'h5060, 8'h77);
    put_byte(8'h50, 1'b0);
    put_byte(8'h60, 1'b1);
    put_entry(16'h00FF, 8'hFE);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    // entry rewritten while FF is held, then read on the very next beat
    put_entry(16'hFFFF, 8'h80);
    put_byte(8'hFF, 1'b1);
  endtask

  task automatic test_codes_mid_stream();
    put_entry(16'h6070, 8'h00);
    put_entry(16'h7000, 8'h00);
    put_byte(8'h60, 1'b0);
    settle();
    set_codes(8'hFF, 8'h00);
    put_byte(8'h70, 1'b1);
  endtask

  task automatic test_random_traffic();
    settle();
    load_pair_table();
    for (int p = 0; p < Phases; p++) begin
      settle();
      if (p == Phases - 1)
        set_codes(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
      else set_codes(PhaseCommon[p], PhaseEscape[p]);
      in_calm  = (p == 0);
      out_calm = (p == 0 || p == 3);
      for (int k = 0; k < PhaseBeats; k++) begin
        if (k == PhaseBeats / 2 && p % 2 == 1) settle();
        send_beat(random_beat());
      end
    end
    in_calm  = 1'b0;
    out_calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_single_byte();
    test_common_pair();
    test_escape_pair();
    test_replaced_pair();
    test_codes_mid_stream();
    test_random_traffic();
    settle();
    if (encoded_q.size() != 0) begin
      n_err++;
      $display("%0t: %0d encoded beats never arrived", $time, encoded_q.size());
    end
    $display("covered %0d input beats (%0d pair table writes), %0d encoded beats, %0d streams",
             n_beats, n_writes, n_results, n_streams);
    $display("across %0d common/escape settings with random gaps and stalls", n_settings);
    if (n_err == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #(10_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
sv/bpse_pkg.sv
sv/bpse_table.sv
sv/bpse_emit.sv
sv/byte_pair_substitution_encoder_top.sv
tb/sv/tb.sv
